// ----- rtl/fia_pkg.sv -----
`default_nettype none
package fia_pkg;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int IVL_W      = 16;
  localparam int SUM_W      = IVL_W + $clog2(RING_DEPTH);
  localparam int FRAC_W     = 8;
  localparam int AVG_W      = 24;
  localparam int FPS_W      = 24;
  localparam int TOTAL_W    = 40;
  localparam int TIME_W     = 32;
  localparam int FC_W       = 16;
  localparam int WT_W       = 32;

  localparam int MS_PER_S   = 1000;
  localparam int MS_W       = 10;
  localparam int NUM_W      = FC_W + MS_W;
  localparam int FPS_SHIFT  = 16;
  localparam int DIV_W      = NUM_W + FPS_SHIFT;
  localparam int DIVISOR_W  = 32;
  localparam int STEP_W     = $clog2(DIV_W + 1);
  localparam int AVG_DVD_W  = SUM_W + FRAC_W;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELAPSED_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS_WINDOW_MS  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [IVL_W-1:0]  data;
  } ring_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } ring_rd_t;

  typedef struct packed {
    logic             valid;
    logic [IVL_W-1:0] data;
  } ring_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [STEP_W-1:0]    steps;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/fia_if.sv -----
`default_nettype none
interface fia_in_if;
  import fia_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface fia_out_if;
  import fia_pkg::*;
  logic               valid;
  logic               ready;
  logic [AVG_W-1:0]   avg_elapsed_q8;
  logic [FPS_W-1:0]   fps_q8;
  logic [TOTAL_W-1:0] total_time_q8;
  logic               window_restarted;
  logic               fps_saturated;

  modport source (output valid, output avg_elapsed_q8, output fps_q8, output total_time_q8,
                  output window_restarted, output fps_saturated, input ready);
  modport sink   (input valid, input avg_elapsed_q8, input fps_q8, input total_time_q8,
                  input window_restarted, input fps_saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/frame_interval_averager_fps_meter_unit.sv -----
`default_nettype none
// Channel   Dir  Payload                                               Transaction
// in_ch     in   now_ms[31:0]                                          valid & ready
// out_ch    out  avg_elapsed_q8, fps_q8, total_time_q8, window_restarted,
//                fps_saturated                                         valid & ready
// cfg       in   cfg_index[1:0], cfg_wdata[15:0]                       cfg_we
//
// Each tick runs in order from acceptance to the result load: the ring write,
// a sweep over the F filled ring slots (1 to 16) that reads one ring entry a
// cycle, then the shared serial divider runs 28 steps on the average and 42 on
// the fps. A tick whose window time is zero skips the fps division.
// Reset clears the slot-written flags at once; there is no clearing pass.
// A new tick is taken only when the previous one has finished; a result held
// in the output register does not block acceptance, only the final load.
module frame_interval_averager_fps_meter_unit
  import fia_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  fia_in_if.sink                    in_ch,
  fia_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SUM, S_DIVA, S_WAITA, S_UPD, S_DIVF, S_WAITF, S_FIN
  } state_t;

  state_t state_r;

  logic [CNT_W-1:0]   samples_r;
  logic [IVL_W-1:0]   max_elapsed_r;
  logic [IVL_W-1:0]   fps_window_r;

  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  prev_time_r;
  logic               seen_r;
  logic [SLOT_W-1:0]  write_slot_r;
  logic [CNT_W-1:0]   filled_r;
  logic [CNT_W-1:0]   issue_r;
  logic [SUM_W-1:0]   sum_r;
  logic [AVG_W-1:0]   avg_r;
  logic [FC_W-1:0]    frame_count_r;
  logic [WT_W-1:0]    window_time_r;
  logic [TIME_W-1:0]  window_start_r;
  logic [TOTAL_W-1:0] total_r;
  logic [NUM_W-1:0]   num_r;
  logic [FPS_W-1:0]   fps_r;
  logic               sat_r;

  logic               out_valid_r;
  logic [AVG_W-1:0]   out_avg_r;
  logic [FPS_W-1:0]   out_fps_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_restart_r;
  logic               out_sat_r;

  div_req_t  div_req_r;
  div_rsp_t  div_rsp;
  ring_wr_t  ring_wr;
  ring_rd_t  ring_rd;
  ring_rsp_t ring_rsp;

  logic [CNT_W-1:0]   size_nxt;
  logic [TIME_W-1:0]  diff_nxt;
  logic [IVL_W-1:0]   interval_nxt;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [CNT_W-1:0]   slot_inc;
  logic [CNT_W-1:0]   filled_lim;
  logic [CNT_W-1:0]   filled_nxt;
  logic [FC_W-1:0]    fc_nxt;
  logic [WT_W:0]      wt_sum;
  logic [WT_W-1:0]    wt_nxt;
  logic [TIME_W-1:0]  since_nxt;
  logic               out_free;

  always_comb begin
    if (samples_r == '0) begin
      size_nxt = CNT_W'(1);
    end else if (samples_r > CNT_W'(RING_DEPTH)) begin
      size_nxt = CNT_W'(RING_DEPTH);
    end else begin
      size_nxt = samples_r;
    end

    diff_nxt = now_r - prev_time_r;
    if (!seen_r) begin
      interval_nxt = '0;
    end else if (diff_nxt > {{(TIME_W-IVL_W){1'b0}}, max_elapsed_r}) begin
      interval_nxt = max_elapsed_r;
    end else begin
      interval_nxt = diff_nxt[IVL_W-1:0];
    end

    // A write pointer left beyond a shrunken ring restarts at slot zero.
    slot_nxt   = ({1'b0, write_slot_r} >= size_nxt) ? '0 : write_slot_r;
    slot_inc   = {1'b0, slot_nxt} + 1'b1;
    filled_lim = (filled_r > size_nxt) ? size_nxt : filled_r;
    filled_nxt = (filled_lim < size_nxt) ? filled_lim + 1'b1 : filled_lim;

    fc_nxt    = (frame_count_r == '1) ? frame_count_r : frame_count_r + 1'b1;
    wt_sum    = {1'b0, window_time_r} + {{(WT_W+1-AVG_W){1'b0}}, avg_r};
    wt_nxt    = wt_sum[WT_W] ? '1 : wt_sum[WT_W-1:0];
    since_nxt = now_r - window_start_r;

    out_free  = !out_valid_r || out_ch.ready;
  end

  // The ring write happens in its own cycle ahead of the sweep, so a read never
  // meets a write to the same slot in flight.
  always_comb begin
    ring_wr.en   = (state_r == S_WRITE);
    ring_wr.addr = slot_nxt;
    ring_wr.data = interval_nxt;
    ring_rd.en   = (state_r == S_SUM) && (issue_r < filled_r);
    ring_rd.addr = issue_r[SLOT_W-1:0];
  end

  fia_ring_mem u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (ring_wr),
    .rd    (ring_rd),
    .rsp   (ring_rsp)
  );

  fia_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r     <= CNT_W'(RING_DEPTH);
      max_elapsed_r <= IVL_W'(100);
      fps_window_r  <= IVL_W'(MS_PER_S);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLES_IN_USE: samples_r     <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_ELAPSED_MS: max_elapsed_r <= cfg_wdata[IVL_W-1:0];
        CFG_FPS_WINDOW_MS:  fps_window_r  <= cfg_wdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      prev_time_r     <= '0;
      seen_r          <= 1'b0;
      write_slot_r    <= '0;
      filled_r        <= '0;
      frame_count_r   <= '0;
      window_time_r   <= '0;
      window_start_r  <= '0;
      total_r         <= '0;
      issue_r         <= '0;
      div_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            now_r   <= in_ch.now_ms;
            state_r <= S_WRITE;
          end
        end

        S_WRITE: begin
          seen_r       <= 1'b1;
          prev_time_r  <= now_r;
          write_slot_r <= (slot_inc >= size_nxt) ? '0 : slot_inc[SLOT_W-1:0];
          filled_r     <= filled_nxt;
          issue_r      <= '0;
          sum_r        <= '0;
          state_r      <= S_SUM;
        end

        S_SUM: begin
          if (ring_rd.en) begin
            issue_r <= issue_r + 1'b1;
          end
          if (ring_rsp.valid) begin
            sum_r <= sum_r + {{(SUM_W-IVL_W){1'b0}}, ring_rsp.data};
          end
          if (!ring_rd.en && !ring_rsp.valid) begin
            state_r <= S_DIVA;
          end
        end

        S_DIVA: begin
          div_req_r.start    <= 1'b1;
          div_req_r.steps    <= STEP_W'(AVG_DVD_W);
          div_req_r.dividend <= {sum_r, {FRAC_W{1'b0}}, {(DIV_W-AVG_DVD_W){1'b0}}};
          div_req_r.divisor  <= {{(DIVISOR_W-CNT_W){1'b0}}, filled_r};
          state_r            <= S_WAITA;
        end

        S_WAITA: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[DIV_W-1:AVG_W] != '0) begin
              avg_r <= '1;
            end else begin
              avg_r <= div_rsp.quotient[AVG_W-1:0];
            end
            state_r <= S_UPD;
          end
        end

        S_UPD: begin
          frame_count_r <= fc_nxt;
          window_time_r <= wt_nxt;
          total_r       <= total_r + {{(TOTAL_W-AVG_W){1'b0}}, avg_r};
          num_r         <= NUM_W'(fc_nxt) * NUM_W'(MS_PER_S);
          state_r       <= S_DIVF;
        end

        S_DIVF: begin
          if (window_time_r == '0) begin
            fps_r   <= '1;
            sat_r   <= 1'b1;
            state_r <= S_FIN;
          end else begin
            div_req_r.start    <= 1'b1;
            div_req_r.steps    <= STEP_W'(DIV_W);
            div_req_r.dividend <= {num_r, {FPS_SHIFT{1'b0}}};
            div_req_r.divisor  <= window_time_r;
            state_r            <= S_WAITF;
          end
        end

        S_WAITF: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[DIV_W-1:FPS_W] != '0) begin
              fps_r <= '1;
              sat_r <= 1'b1;
            end else begin
              fps_r <= div_rsp.quotient[FPS_W-1:0];
              sat_r <= 1'b0;
            end
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_avg_r     <= avg_r;
            out_fps_r     <= fps_r;
            out_total_r   <= total_r;
            out_sat_r     <= sat_r;
            out_restart_r <= (since_nxt > {{(TIME_W-IVL_W){1'b0}}, fps_window_r});
            if (since_nxt > {{(TIME_W-IVL_W){1'b0}}, fps_window_r}) begin
              frame_count_r  <= '0;
              window_time_r  <= '0;
              window_start_r <= now_r;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.avg_elapsed_q8   = out_avg_r;
  assign out_ch.fps_q8           = out_fps_r;
  assign out_ch.total_time_q8    = out_total_r;
  assign out_ch.window_restarted = out_restart_r;
  assign out_ch.fps_saturated    = out_sat_r;

  a_div_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_req_r.start |-> (state_r == S_WAITA || state_r == S_WAITF))
    else $error("divider started outside a divide phase");

  a_ring_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ring_rd.en |-> (filled_r != '0 && filled_r <= CNT_W'(RING_DEPTH)))
    else $error("ring read with an invalid fill count");

  a_out_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the final step");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_fps_r == '1))
    else $error("saturated fps result without the saturated value");

endmodule
`default_nettype wire

// ----- rtl/fia_ring_mem.sv -----
`default_nettype none
module fia_ring_mem
  import fia_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ring_wr_t  wr,
  input  wire ring_rd_t  rd,
  output ring_rsp_t      rsp
);

  logic [IVL_W-1:0]      mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] written_r;
  logic [IVL_W-1:0]      rdata_r;
  logic                  rvalid_r;
  logic                  rwritten_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[rd.addr];
  end

  // Slots never written read as zero, matching the cleared ring after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r  <= '0;
      rvalid_r   <= 1'b0;
      rwritten_r <= 1'b0;
    end else begin
      if (wr.en) begin
        written_r[wr.addr] <= 1'b1;
      end
      rvalid_r   <= rd.en;
      rwritten_r <= written_r[rd.addr];
    end
  end

  assign rsp.valid = rvalid_r;
  assign rsp.data  = rwritten_r ? rdata_r : '0;

endmodule
`default_nettype wire

// ----- rtl/fia_divider.sv -----
`default_nettype none
module fia_divider
  import fia_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [DIVISOR_W-1:0] divisor_r;
  logic [STEP_W-1:0]    cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0]   trial;
  logic                 qbit;
  logic [DIVISOR_W:0]   diff;

  // Restoring division, one quotient bit per cycle. The quotient bits shift in
  // at the bottom of the dividend register as the dividend shifts out the top.
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, divisor_r};
    qbit  = (trial >= {1'b0, divisor_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r     <= '0;
        dvd_r     <= req.dividend;
        divisor_r <= req.divisor;
        cnt_r     <= req.steps;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        dvd_r <= {dvd_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
`default_nettype wire
